>>> hw/rtl/asds_pkg.sv
// Shared types and constants for the input axis dead zone smoother.
`default_nettype none
package asds_pkg;

  localparam int unsigned KEY_MAX = 16;
  localparam int unsigned KW = 5;
  localparam int unsigned XW = 38;
  localparam int unsigned AW = 37;
  localparam int unsigned SQW = 75;
  localparam int unsigned SUMW = 76;
  localparam int unsigned NW = 108;
  localparam int unsigned P1W = 91;
  localparam int unsigned OPW = 19;
  localparam int unsigned PRW = 38;

  typedef struct packed {
    logic [7:0]         y_mask;
    logic signed [15:0] gain_x;
    logic signed [15:0] gain_y;
    logic [14:0]        dead_zone;
    logic [19:0]        smooth_time;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_Y_MASK = 3'd0,
    REG_GAIN_X = 3'd1,
    REG_GAIN_Y = 3'd2,
    REG_DEAD_ZONE = 3'd3,
    REG_SMOOTH_TIME = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE, S_TAKE, S_SUM, S_CMP, S_NA, S_NB, S_DIV0, S_DIV, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    MOP_GX, MOP_GY, MOP_XHH, MOP_XHL, MOP_XLL, MOP_YHH, MOP_YHL, MOP_YLL,
    MOP_DZ, MOP_SX, MOP_SY
  } mul_op_e;

endpackage
`default_nettype wire

>>> hw/rtl/asds_mul.sv
// Shared unsigned multiplier with a registered product.
`default_nettype none
module asds_mul import asds_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic [OPW-1:0] a_i,
  input  wire logic [OPW-1:0] b_i,
  output logic      [PRW-1:0] prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end

endmodule
`default_nettype wire

>>> hw/rtl/asds_core.sv
// Sequencer and datapath that form, shape and smooth the axis vector.
`default_nettype none
module asds_core import asds_pkg::*; #(
  parameter int unsigned NUM_KEY_PAIRS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [7:0]         neg_i,
  input  wire logic [7:0]         pos_i,
  input  wire logic signed [15:0] dx_i,
  input  wire logic signed [15:0] dy_i,
  input  wire logic [19:0]        dt_i,
  input  wire cfg_t               cfg_i,
  input  wire logic               res_free_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [15:0]      sx_o,
  output logic signed [15:0]      sy_o,
  output logic signed [15:0]      rx_o,
  output logic signed [15:0]      ry_o
);

  state_e state_q, state_d;
  mul_op_e mop_q;
  logic [3:0] bit_q;
  logic comp_q;
  logic signed [KW-1:0] kx_q, ky_q, kx_d, ky_d;
  logic signed [15:0] dx_q, dy_q;
  logic [19:0] dt_q;
  logic signed [XW-1:0] x_q, y_q;
  logic [SQW-1:0] sqx_q, sqy_q;
  logic [29:0] dz2_q;
  logic [SUMW-1:0] sq_q;
  logic [14:0] q_q, qnew;
  logic [P1W-1:0] p1_q;
  logic [NW-1:0] p2_q, tmp_q, lhs, t2;
  logic take;
  logic signed [15:0] rx_q, ry_q, sx_q, sy_q, qs;
  logic [19:0] rem_q;
  logic [20:0] r2;
  logic [14:0] tq_q;
  logic [KEY_MAX-1:0] negx, posx, mskx;
  logic signed [1:0] dk;
  logic [XW-1:0] axf, ayf;
  logic [AW-1:0] ax, ay;
  logic [16:0] mdx, mdy, mgx, mgy;
  logic signed [16:0] difx, dify;
  logic [16:0] mdifx, mdify;
  logic [OPW-1:0] op_a, op_b;
  logic [PRW-1:0] prod;
  logic signed [XW-1:0] pv;
  logic signed [16:0] step;
  logic sgn;

  asds_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  always_comb begin
    negx = KEY_MAX'(neg_i);
    posx = KEY_MAX'(pos_i);
    mskx = KEY_MAX'(cfg_i.y_mask);
    kx_d = '0;
    ky_d = '0;
    for (int i = 0; i < NUM_KEY_PAIRS; i++) begin
      dk = (posx[i] && !negx[i]) ? 2'sd1 : ((negx[i] && !posx[i]) ? -2'sd1 : 2'sd0);
      if (mskx[i]) begin
        ky_d = ky_d + KW'(dk);
      end else begin
        kx_d = kx_d + KW'(dk);
      end
    end
  end

  always_comb begin
    axf = x_q[XW-1] ? -x_q : x_q;
    ayf = y_q[XW-1] ? -y_q : y_q;
    ax = axf[AW-1:0];
    ay = ayf[AW-1:0];
    mdx = dx_q[15] ? -{dx_q[15], dx_q} : {1'b0, dx_q};
    mdy = dy_q[15] ? -{dy_q[15], dy_q} : {1'b0, dy_q};
    mgx = cfg_i.gain_x[15] ? -{cfg_i.gain_x[15], cfg_i.gain_x} : {1'b0, cfg_i.gain_x};
    mgy = cfg_i.gain_y[15] ? -{cfg_i.gain_y[15], cfg_i.gain_y} : {1'b0, cfg_i.gain_y};
    difx = {rx_q[15], rx_q} - {sx_q[15], sx_q};
    dify = {ry_q[15], ry_q} - {sy_q[15], sy_q};
    mdifx = difx[16] ? -difx : difx;
    mdify = dify[16] ? -dify : dify;
  end

  always_comb begin
    case (mop_q)
      MOP_GX:  begin op_a = OPW'(mdx); op_b = OPW'(mgx); end
      MOP_GY:  begin op_a = OPW'(mdy); op_b = OPW'(mgy); end
      MOP_XHH: begin op_a = OPW'(ax[AW-1:19]); op_b = OPW'(ax[AW-1:19]); end
      MOP_XHL: begin op_a = OPW'(ax[AW-1:19]); op_b = ax[18:0]; end
      MOP_XLL: begin op_a = ax[18:0]; op_b = ax[18:0]; end
      MOP_YHH: begin op_a = OPW'(ay[AW-1:19]); op_b = OPW'(ay[AW-1:19]); end
      MOP_YHL: begin op_a = OPW'(ay[AW-1:19]); op_b = ay[18:0]; end
      MOP_YLL: begin op_a = ay[18:0]; op_b = ay[18:0]; end
      MOP_DZ:  begin op_a = OPW'(cfg_i.dead_zone); op_b = OPW'(cfg_i.dead_zone); end
      MOP_SX:  begin op_a = OPW'(mdifx); op_b = OPW'(tq_q); end
      MOP_SY:  begin op_a = OPW'(mdify); op_b = OPW'(tq_q); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    sgn = (mop_q == MOP_GX) ? (dx_q[15] ^ cfg_i.gain_x[15]) : (dy_q[15] ^ cfg_i.gain_y[15]);
    pv = sgn ? -XW'(prod[30:0]) : XW'(prod[30:0]);
    step = (mop_q == MOP_SX) ? (difx[16] ? -{1'b0, prod[29:14]} : {1'b0, prod[29:14]})
                             : (dify[16] ? -{1'b0, prod[29:14]} : {1'b0, prod[29:14]});
    lhs = NW'(comp_q ? sqy_q : sqx_q) << 28;
    t2 = tmp_q + (NW'(sq_q) << {bit_q, 1'b0});
    take = !(lhs < t2);
    qnew = take ? (q_q | (15'd1 << bit_q)) : q_q;
    qs = (comp_q ? y_q[XW-1] : x_q[XW-1]) ? -{1'b0, qnew} : {1'b0, qnew};
    r2 = {rem_q, 1'b0};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_ISSUE;
      S_ISSUE: state_d = S_TAKE;
      S_TAKE: begin
        if (mop_q == MOP_DZ) begin
          state_d = S_SUM;
        end else if (mop_q == MOP_SY) begin
          state_d = S_DONE;
        end else begin
          state_d = S_ISSUE;
        end
      end
      S_SUM: state_d = S_CMP;
      S_CMP: begin
        if (sq_q < SUMW'(dz2_q)) begin
          state_d = S_DIV0;
        end else if (sq_q > (SUMW'(1) << 28)) begin
          state_d = S_NA;
        end else begin
          state_d = S_DIV0;
        end
      end
      S_NA: state_d = S_NB;
      S_NB: begin
        if (bit_q == 4'd0 && comp_q) begin
          state_d = S_DIV0;
        end else begin
          state_d = S_NA;
        end
      end
      S_DIV0: begin
        if (cfg_i.smooth_time == '0) begin
          state_d = S_DONE;
        end else if (dt_q >= cfg_i.smooth_time) begin
          state_d = S_ISSUE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: if (bit_q == 4'd0) state_d = S_ISSUE;
      S_DONE: if (res_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != S_IDLE);
    done_o = (state_q == S_DONE) && res_free_i;
    sx_o = sx_q;
    sy_o = sy_q;
    rx_o = rx_q;
    ry_o = ry_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mop_q <= MOP_GX;
      bit_q <= '0;
      comp_q <= 1'b0;
      sx_q <= '0;
      sy_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: mop_q <= MOP_GX;
        S_TAKE: begin
          case (mop_q)
            MOP_GX:  mop_q <= MOP_GY;
            MOP_GY:  mop_q <= MOP_XHH;
            MOP_XHH: mop_q <= MOP_XHL;
            MOP_XHL: mop_q <= MOP_XLL;
            MOP_XLL: mop_q <= MOP_YHH;
            MOP_YHH: mop_q <= MOP_YHL;
            MOP_YHL: mop_q <= MOP_YLL;
            MOP_YLL: mop_q <= MOP_DZ;
            MOP_SX:  mop_q <= MOP_SY;
            MOP_SY:  sy_q <= sy_q + step[15:0];
            default: mop_q <= mop_q;
          endcase
          if (mop_q == MOP_SX) sx_q <= sx_q + step[15:0];
        end
        S_CMP: begin
          comp_q <= 1'b0;
          bit_q <= 4'd14;
        end
        S_NB: begin
          if (bit_q == 4'd0) begin
            comp_q <= 1'b1;
            bit_q <= 4'd14;
          end else begin
            bit_q <= bit_q - 4'd1;
          end
        end
        S_DIV0: begin
          mop_q <= MOP_SX;
          bit_q <= 4'd13;
          if (cfg_i.smooth_time == '0) begin
            sx_q <= rx_q;
            sy_q <= ry_q;
          end
        end
        S_DIV: bit_q <= bit_q - 4'd1;
        default: bit_q <= bit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        kx_q <= kx_d;
        ky_q <= ky_d;
        dx_q <= dx_i;
        dy_q <= dy_i;
        dt_q <= dt_i;
      end
      S_TAKE: begin
        case (mop_q)
          MOP_GX:  x_q <= (XW'(kx_q) <<< 14) + (pv <<< 6);
          MOP_GY:  y_q <= (XW'(ky_q) <<< 14) + (pv <<< 6);
          MOP_XHH: sqx_q <= SQW'(prod) << 38;
          MOP_XHL: sqx_q <= sqx_q + (SQW'(prod) << 20);
          MOP_XLL: sqx_q <= sqx_q + SQW'(prod);
          MOP_YHH: sqy_q <= SQW'(prod) << 38;
          MOP_YHL: sqy_q <= sqy_q + (SQW'(prod) << 20);
          MOP_YLL: sqy_q <= sqy_q + SQW'(prod);
          MOP_DZ:  dz2_q <= prod[29:0];
          default: dz2_q <= dz2_q;
        endcase
      end
      S_SUM: sq_q <= SUMW'(sqx_q) + SUMW'(sqy_q);
      S_CMP: begin
        q_q <= '0;
        p1_q <= '0;
        p2_q <= '0;
        if (sq_q < SUMW'(dz2_q)) begin
          rx_q <= '0;
          ry_q <= '0;
        end else begin
          rx_q <= x_q[15:0];
          ry_q <= y_q[15:0];
        end
      end
      S_NA: tmp_q <= p2_q + (NW'(p1_q) << (bit_q + 4'd1));
      S_NB: begin
        if (bit_q == 4'd0) begin
          q_q <= '0;
          p1_q <= '0;
          p2_q <= '0;
          if (comp_q) begin
            ry_q <= qs;
          end else begin
            rx_q <= qs;
          end
        end else begin
          q_q <= qnew;
          if (take) begin
            p2_q <= t2;
            p1_q <= p1_q + (P1W'(sq_q) << bit_q);
          end
        end
      end
      S_DIV0: begin
        rem_q <= dt_q;
        tq_q <= (dt_q >= cfg_i.smooth_time) ? 15'd16384 : 15'd0;
      end
      S_DIV: begin
        if (r2 >= {1'b0, cfg_i.smooth_time}) begin
          rem_q <= 20'(r2 - {1'b0, cfg_i.smooth_time});
          tq_q <= {tq_q[13:0], 1'b1};
        end else begin
          rem_q <= r2[19:0];
          tq_q <= {tq_q[13:0], 1'b0};
        end
      end
      default: tq_q <= tq_q;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/input_axis_deadzone_smoother.sv
// Top level of the input axis dead zone smoother with its register port.
//
//   Channel | Direction | Handshake               | Payload
//   input   | in        | in_valid_i / in_stall_o | key bits, mouse deltas, elapsed time
//   output  | out       | out_valid_o / out_stall_i | smoothed and raw values, nonzero
//   config  | in        | APB psel / penable      | five registers at 4*i
//
// An item is taken only while the core is idle; the next item can be taken in the cycle
// after its result is registered. The shared multiplier computes nine products always,
// two more when smoothing. Normalizing adds two 15-step searches, the divider 14 steps.
// Reset clears the smoothed value and sets the registers to their defaults.
// The block accepts the next item while a finished item waits on a stalled output.
`default_nettype none
module input_axis_deadzone_smoother import asds_pkg::*; #(
  parameter int unsigned NUM_KEY_PAIRS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         negative_pressed_i,
  input  wire logic [7:0]         positive_pressed_i,
  input  wire logic signed [15:0] mouse_dx_i,
  input  wire logic signed [15:0] mouse_dy_i,
  input  wire logic [19:0]        elapsed_time_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      value_x_o,
  output logic signed [15:0]      value_y_o,
  output logic signed [15:0]      raw_x_o,
  output logic signed [15:0]      raw_y_o,
  output logic                    nonzero_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t cfg_q;
  reg_idx_e idx;
  logic busy, done, res_free, start, out_valid_q;
  logic signed [15:0] sx, sy, rx, ry;

  assign idx = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.y_mask <= '0;
      cfg_q.gain_x <= 16'sd256;
      cfg_q.gain_y <= '0;
      cfg_q.dead_zone <= '0;
      cfg_q.smooth_time <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_Y_MASK:      cfg_q.y_mask <= pwdata[7:0];
        REG_GAIN_X:      cfg_q.gain_x <= pwdata[15:0];
        REG_GAIN_Y:      cfg_q.gain_y <= pwdata[15:0];
        REG_DEAD_ZONE:   cfg_q.dead_zone <= pwdata[14:0];
        REG_SMOOTH_TIME: cfg_q.smooth_time <= pwdata[19:0];
        default:         cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_Y_MASK:      prdata = 32'(cfg_q.y_mask);
      REG_GAIN_X:      prdata = 32'(cfg_q.gain_x);
      REG_GAIN_Y:      prdata = 32'(cfg_q.gain_y);
      REG_DEAD_ZONE:   prdata = 32'(cfg_q.dead_zone);
      REG_SMOOTH_TIME: prdata = 32'(cfg_q.smooth_time);
      default:         prdata = '0;
    endcase
  end

  assign in_stall_o = busy;
  assign start = in_valid_i && !busy;
  assign res_free = !out_valid_q || !out_stall_i;

  asds_core #(
    .NUM_KEY_PAIRS (NUM_KEY_PAIRS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .neg_i      (negative_pressed_i),
    .pos_i      (positive_pressed_i),
    .dx_i       (mouse_dx_i),
    .dy_i       (mouse_dy_i),
    .dt_i       (elapsed_time_i),
    .cfg_i      (cfg_q),
    .res_free_i (res_free),
    .busy_o     (busy),
    .done_o     (done),
    .sx_o       (sx),
    .sy_o       (sy),
    .rx_o       (rx),
    .ry_o       (ry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      value_x_o <= sx;
      value_y_o <= sy;
      raw_x_o <= rx;
      raw_y_o <= ry;
      nonzero_o <= (sx != '0) || (sy != '0);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
